[rtl/core/spi_flash_command_sequencer_top_assert.svh]
// Assertion macros for the flash command sequencer checker.
`ifndef SPI_FLASH_COMMAND_SEQUENCER_TOP_ASSERT_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_TOP_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define SFCS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("sfcs check failed");
// Next-cycle implication outside reset.
`define SFCS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("sfcs check failed");
`endif

[rtl/core/sfcs_pkg.sv]
// Shared constants and types of the flash command sequencer.
`default_nettype none
package sfcs_pkg;
  localparam int PAGE_BYTES = 256;
  localparam int PW = $clog2(PAGE_BYTES);
  localparam int CW = PW + 1;

  localparam logic [7:0] CMD_ID   = 8'h9F;
  localparam logic [7:0] CMD_WEN  = 8'h06;
  localparam logic [7:0] CMD_RDSR = 8'h05;
  localparam logic [7:0] CMD_SE   = 8'h20;
  localparam logic [7:0] CMD_PP   = 8'h02;
  localparam logic [7:0] CMD_READ = 8'h03;
  localparam logic [7:0] DUMMY    = 8'hFF;

  localparam logic [1:0] MODE_REQ  = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;

  localparam logic [1:0] OP_ID    = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  localparam logic [2:0] ACT_SEL_LOW  = 3'd0;
  localparam logic [2:0] ACT_SEND     = 3'd1;
  localparam logic [2:0] ACT_SEL_HIGH = 3'd2;
  localparam logic [2:0] ACT_READ     = 3'd3;
  localparam logic [2:0] ACT_IDENT    = 3'd4;
  localparam logic [2:0] ACT_DONE     = 3'd5;
  localparam logic [2:0] ACT_NEED     = 3'd6;
  localparam logic [2:0] ACT_REJECT   = 3'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  op;
    logic [23:0] address;
    logic [15:0] length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] value;
  } res_t;

  // Up to four results per item, count 0..4.
  typedef struct packed {
    logic [2:0] cnt;
    res_t [3:0] r;
  } burst_t;
endpackage
`default_nettype wire

[rtl/core/sfcs_front.sv]
// Front end: takes items, drops those that can never act, queues the rest.
`default_nettype none
module sfcs_front (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  sfcs_pkg::item_t       in_item,
  output logic                  q_valid,
  input  wire                   q_ready,
  output sfcs_pkg::item_t       q_item
);
  import sfcs_pkg::*;
  item_t      mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       push, pop, keep;

  // Mode 3 never produces a result; drop it here.
  assign keep     = (in_item.mode != 2'd3);
  assign in_ready = (cnt_r != 3'd4);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 3'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'd0, push} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/core/sfcs_back.sv]
// Back end: command state machine, one queued item per step, then result drain.
`default_nettype none
module sfcs_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  output logic                  q_ready,
  input  sfcs_pkg::item_t       q_item,
  output logic                  out_valid,
  input  wire                   out_ready,
  output sfcs_pkg::res_t        out_res,
  output logic                  out_last
);
  import sfcs_pkg::*;
  localparam logic [3:0] PH_IDLE = 4'd0, PH_ID = 4'd1, PH_WEN = 4'd2, PH_ADDR = 4'd3,
                         PH_READ = 4'd4, PH_NEED = 4'd5, PH_DATA = 4'd6,
                         PH_POLLCMD = 4'd7, PH_POLL = 4'd8;
  localparam logic [1:0] NX_ERASE = 2'd1, NX_FINAL = 2'd2, NX_PAGE = 2'd3;

  logic [3:0]  ph_r, ph_nxt;
  logic [1:0]  aop_r, aop_nxt;
  logic [23:0] cur_r, cur_nxt;
  logic [15:0] left_r, left_nxt;
  logic [CW-1:0] chk_r, chk_nxt;
  logic [1:0]  fi_r, fi_nxt;
  logic [23:0] ida_r, ida_nxt;
  logic [1:0]  apn_r, apn_nxt;
  burst_t      bur_r, bur_nxt, b;
  logic [2:0]  oi_r, oi_nxt;
  logic        busy, step;
  logic [CW-1:0] room;
  logic [15:0]   left_dec;

  // Results drain one per cycle while out_ready is high; the next item waits.
  assign busy      = (oi_r != bur_r.cnt);
  assign q_ready   = !busy;
  assign step      = q_valid && !busy;
  assign out_valid = busy;
  assign out_res   = bur_r.r[oi_r[1:0]];
  assign out_last  = (oi_r + 3'd1 == bur_r.cnt);
  assign room      = CW'(PAGE_BYTES) - {1'b0, cur_r[PW-1:0]};
  assign left_dec  = left_r - 16'd1;

  function automatic burst_t put(burst_t x, logic [2:0] a, logic [23:0] v);
    burst_t y;
    y = x;
    if (x.cnt != 3'd4) begin
      y.r[x.cnt[1:0]] = '{action: a, value: v};
      y.cnt = x.cnt + 3'd1;
    end
    return y;
  endfunction

  always_comb begin
    ph_nxt = ph_r; aop_nxt = aop_r; cur_nxt = cur_r; left_nxt = left_r;
    chk_nxt = chk_r; fi_nxt = fi_r; ida_nxt = ida_r; apn_nxt = apn_r;
    b = '0;
    case (q_item.mode)
      MODE_REQ: begin
        if (ph_r != PH_IDLE) begin
          b = put(b, ACT_REJECT, '0);
        end else begin
          aop_nxt = q_item.op; cur_nxt = q_item.address; left_nxt = q_item.length;
          fi_nxt = '0; chk_nxt = '0; apn_nxt = '0;
          case (q_item.op)
            OP_ID: begin
              ida_nxt = '0;
              b = put(b, ACT_SEL_LOW, '0); b = put(b, ACT_SEND, {16'd0, CMD_ID});
              ph_nxt = PH_ID;
            end
            OP_READ: begin
              b = put(b, ACT_SEL_LOW, '0); b = put(b, ACT_SEND, {16'd0, CMD_READ});
              ph_nxt = PH_ADDR;
            end
            OP_ERASE: begin
              b = put(b, ACT_SEL_LOW, '0); b = put(b, ACT_SEND, {16'd0, CMD_WEN});
              ph_nxt = PH_WEN;
            end
            default: begin
              if (q_item.length == 16'd0) begin
                b = put(b, ACT_DONE, '0);
                ph_nxt = PH_IDLE;
              end else begin
                chk_nxt = ({{(CW-1){1'b0}}, 1'b0} | CW'(PAGE_BYTES)) -
                          {1'b0, q_item.address[PW-1:0]};
                if ({{(16-CW){1'b0}}, chk_nxt} > q_item.length) chk_nxt = CW'(q_item.length);
                b = put(b, ACT_SEL_LOW, '0); b = put(b, ACT_SEND, {16'd0, CMD_WEN});
                ph_nxt = PH_WEN;
              end
            end
          endcase
        end
      end
      MODE_RX: begin
        case (ph_r)
          PH_ID: begin
            if (fi_r != 2'd0) ida_nxt = {ida_r[15:0], q_item.data_byte};
            if (fi_r != 2'd3) begin
              b = put(b, ACT_SEND, {16'd0, DUMMY});
              fi_nxt = fi_r + 2'd1;
            end else begin
              // identity word includes the byte arriving now
              b = put(b, ACT_SEL_HIGH, '0); b = put(b, ACT_IDENT, ida_nxt);
              b = put(b, ACT_DONE, '0);
              ph_nxt = PH_IDLE;
            end
          end
          PH_WEN: begin
            b = put(b, ACT_SEL_HIGH, '0); b = put(b, ACT_SEL_LOW, '0);
            if (aop_r == OP_ERASE) begin
              b = put(b, ACT_SEND, {16'd0, CMD_RDSR});
              apn_nxt = NX_ERASE; ph_nxt = PH_POLLCMD;
            end else begin
              b = put(b, ACT_SEND, {16'd0, CMD_PP});
              fi_nxt = '0; ph_nxt = PH_ADDR;
            end
          end
          PH_ADDR: begin
            if (fi_r != 2'd3) begin
              case (fi_r)
                2'd0:    b = put(b, ACT_SEND, {16'd0, cur_r[23:16]});
                2'd1:    b = put(b, ACT_SEND, {16'd0, cur_r[15:8]});
                default: b = put(b, ACT_SEND, {16'd0, cur_r[7:0]});
              endcase
              fi_nxt = fi_r + 2'd1;
            end else if (aop_r == OP_READ) begin
              if (left_r != 16'd0) begin
                b = put(b, ACT_SEND, {16'd0, DUMMY}); ph_nxt = PH_READ;
              end else begin
                b = put(b, ACT_SEL_HIGH, '0); b = put(b, ACT_DONE, '0); ph_nxt = PH_IDLE;
              end
            end else if (aop_r == OP_ERASE) begin
              b = put(b, ACT_SEL_HIGH, '0); b = put(b, ACT_SEL_LOW, '0);
              b = put(b, ACT_SEND, {16'd0, CMD_RDSR});
              apn_nxt = NX_FINAL; ph_nxt = PH_POLLCMD;
            end else begin
              b = put(b, ACT_NEED, '0); ph_nxt = PH_NEED;
            end
          end
          PH_READ: begin
            b = put(b, ACT_READ, {16'd0, q_item.data_byte});
            left_nxt = left_dec;
            if (left_dec != 16'd0) begin
              b = put(b, ACT_SEND, {16'd0, DUMMY});
            end else begin
              b = put(b, ACT_SEL_HIGH, '0); b = put(b, ACT_DONE, '0); ph_nxt = PH_IDLE;
            end
          end
          PH_DATA: begin
            if (chk_r != '0) begin
              b = put(b, ACT_NEED, '0); ph_nxt = PH_NEED;
            end else begin
              b = put(b, ACT_SEL_HIGH, '0); b = put(b, ACT_SEL_LOW, '0);
              b = put(b, ACT_SEND, {16'd0, CMD_RDSR});
              apn_nxt = NX_PAGE; ph_nxt = PH_POLLCMD;
            end
          end
          PH_POLLCMD: begin
            b = put(b, ACT_SEND, {16'd0, DUMMY}); ph_nxt = PH_POLL;
          end
          PH_POLL: begin
            if (q_item.data_byte[0]) begin
              b = put(b, ACT_SEND, {16'd0, DUMMY});
            end else begin
              b = put(b, ACT_SEL_HIGH, '0);
              if (apn_r == NX_ERASE) begin
                b = put(b, ACT_SEL_LOW, '0); b = put(b, ACT_SEND, {16'd0, CMD_SE});
                fi_nxt = '0; ph_nxt = PH_ADDR;
              end else if (apn_r == NX_PAGE && left_r != 16'd0) begin
                chk_nxt = room;
                if ({{(16-CW){1'b0}}, room} > left_r) chk_nxt = CW'(left_r);
                b = put(b, ACT_SEL_LOW, '0); b = put(b, ACT_SEND, {16'd0, CMD_WEN});
                ph_nxt = PH_WEN;
              end else begin
                b = put(b, ACT_DONE, '0); ph_nxt = PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      default: begin
        if (ph_r == PH_NEED) begin
          b = put(b, ACT_SEND, {16'd0, q_item.data_byte});
          if (chk_r != '0) chk_nxt = chk_r - CW'(1);
          left_nxt = left_dec;
          cur_nxt = cur_r + 24'd1;
          ph_nxt = PH_DATA;
        end
      end
    endcase
    bur_nxt = step ? b : bur_r;
    oi_nxt  = step ? 3'd0 : ((out_valid && out_ready) ? oi_r + 3'd1 : oi_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE; aop_r <= '0; cur_r <= '0; left_r <= '0; chk_r <= '0;
      fi_r <= '0; ida_r <= '0; apn_r <= '0; bur_r <= '0; oi_r <= '0;
    end else begin
      oi_r  <= oi_nxt;
      bur_r <= bur_nxt;
      if (step) begin
        ph_r <= ph_nxt; aop_r <= aop_nxt; cur_r <= cur_nxt; left_r <= left_nxt;
        chk_r <= chk_nxt; fi_r <= fi_nxt; ida_r <= ida_nxt; apn_r <= apn_nxt;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/spi_flash_command_sequencer_top.sv]
// Top level of the serial NOR flash command sequencer.
// Usage:
//  - in_* channel: one transaction per event: host request, byte received from
//    the flash, or host write byte (in_tuser = mode). Mode 3 is dropped.
//  - out_* channel: 0..4 result transactions per event, action in out_tuser,
//    value in out_tdata, out_tlast on the final result of the event.
//  - A queued event is evaluated as the back end takes it; its first result
//    appears on the next cycle, then one per cycle unless out_tready is low.
//  - The back end takes the next event only once every result of the
//    previous event has drained; the result drain sets the event rate.
//  - A four-entry queue separates intake from the back end, so events are
//    accepted while results wait on a stalled receiver.
//  - Events that give no result (stray bytes) leave nothing to drain.
//  - Reset (rst_n low, synchronous) empties the queue, drops pending
//    results and returns the sequencer to idle.
//  - When out_tready is low the current result holds; intake keeps going
//    until the queue is full.
`default_nettype none
module spi_flash_command_sequencer_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [55:0] in_tdata,  // op[1:0], address[25:2], length[41:26], data_byte[49:42]
  input  wire  [1:0]  in_tuser,  // mode[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [23:0] out_tdata, // value[23:0]
  output logic [2:0]  out_tuser, // action[2:0]
  output logic        out_tlast  // last
);
  import sfcs_pkg::*;
  item_t in_item, q_item;
  res_t  res;
  logic  q_valid, q_ready;

  assign in_item = '{mode: in_tuser, op: in_tdata[1:0], address: in_tdata[25:2],
                     length: in_tdata[41:26], data_byte: in_tdata[49:42]};

  sfcs_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  sfcs_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res), .out_last(out_tlast)
  );

  assign out_tdata = res.value;
  assign out_tuser = res.action;
endmodule
`default_nettype wire

[rtl/core/sfcs_checker.sv]
// Port-level checker for the flash command sequencer, bound to the top level.
`default_nettype none
`include "spi_flash_command_sequencer_top_assert.svh"
module sfcs_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata,
  input wire [2:0]  out_tuser,
  input wire        out_tlast
);
  import sfcs_pkg::*;
  `SFCS_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SFCS_ASSERT_IMP(a_done_last, clk, rst_n, out_tvalid && (out_tuser == ACT_DONE), out_tlast)
  `SFCS_ASSERT_IMP(a_rej_last, clk, rst_n, out_tvalid && (out_tuser == ACT_REJECT), out_tlast && (out_tdata == 24'd0))
  `SFCS_ASSERT_IMP(a_byte_width, clk, rst_n, out_tvalid && (out_tuser == ACT_SEND || out_tuser == ACT_READ), out_tdata[23:8] == 16'd0)
endmodule
bind spi_flash_command_sequencer_top sfcs_checker u_sfcs_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);
`default_nettype wire

[tb/sv/sfcs_checker.sv]
// Checker for the flash command sequencer: predicts results and compares them.
`timescale 1ns / 100ps
`default_nettype none
module sfcs_scoreboard (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [55:0] in_tdata,
  input  wire  [1:0]  in_tuser,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [23:0] out_tdata,
  input  wire  [2:0]  out_tuser,
  input  wire         out_tlast,
  output int          fail_count,
  output int          pending_count
);
  import sfcs_pkg::*;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_ID, SQ_WEN, SQ_ADDR, SQ_READ, SQ_NEED, SQ_DATA, SQ_POLLCMD, SQ_POLL
  } seq_phase_t;
  typedef enum logic [1:0] {AFTER_NONE, AFTER_ERASE, AFTER_FINAL, AFTER_PAGE} after_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] value;
    logic        last;
  } flash_res_t;

  seq_phase_t   sq_phase;
  logic [1:0]   sq_op;
  logic [23:0]  sq_addr;
  logic [15:0]  sq_left;
  logic [8:0]   sq_chunk;
  logic [1:0]   sq_frame;
  logic [23:0]  sq_ident;
  after_t       sq_after;
  flash_res_t   expected_results[$];
  flash_res_t   burst[$];

  function automatic void push_res(logic [2:0] a, logic [23:0] v);
    flash_res_t r;
    r.action = a;
    r.value = v;
    r.last = 1'b0;
    burst.push_back(r);
  endfunction

  function automatic void load_chunk();
    logic [8:0] room;
    room = 9'(PAGE_BYTES) - 9'(sq_addr[7:0]);
    sq_chunk = (17'(sq_left) < 17'(room)) ? sq_left[8:0] : room;
  endfunction

  function automatic void begin_poll(after_t nxt);
    push_res(ACT_SEL_HIGH, 0);
    push_res(ACT_SEL_LOW, 0);
    push_res(ACT_SEND, 24'(CMD_RDSR));
    sq_after = nxt;
    sq_phase = SQ_POLLCMD;
  endfunction

  function automatic void begin_wen();
    push_res(ACT_SEL_LOW, 0);
    push_res(ACT_SEND, 24'(CMD_WEN));
    sq_phase = SQ_WEN;
  endfunction

  function automatic void complete();
    push_res(ACT_DONE, 0);
    sq_phase = SQ_IDLE;
  endfunction

  function automatic void predict_sequencer(item_t it);
    logic [7:0] b;
    b = it.data_byte;
    burst.delete();
    if (it.mode == MODE_REQ) begin
      if (sq_phase != SQ_IDLE) begin
        push_res(ACT_REJECT, 0);
      end else begin
        sq_op = it.op;
        sq_addr = it.address;
        sq_left = it.length;
        sq_frame = 0;
        sq_chunk = 0;
        sq_after = AFTER_NONE;
        case (it.op)
          OP_ID: begin
            sq_ident = 0;
            push_res(ACT_SEL_LOW, 0);
            push_res(ACT_SEND, 24'(CMD_ID));
            sq_phase = SQ_ID;
          end
          OP_READ: begin
            push_res(ACT_SEL_LOW, 0);
            push_res(ACT_SEND, 24'(CMD_READ));
            sq_phase = SQ_ADDR;
          end
          OP_ERASE: begin_wen();
          default: begin
            if (it.length == 0) complete();
            else begin
              load_chunk();
              begin_wen();
            end
          end
        endcase
      end
    end else if (it.mode == MODE_RX) begin
      case (sq_phase)
        SQ_ID: begin
          if (sq_frame != 0) sq_ident = {sq_ident[15:0], b};
          if (sq_frame < 3) begin
            push_res(ACT_SEND, 24'(DUMMY));
            sq_frame++;
          end else begin
            push_res(ACT_SEL_HIGH, 0);
            push_res(ACT_IDENT, sq_ident);
            complete();
          end
        end
        SQ_WEN: begin
          push_res(ACT_SEL_HIGH, 0);
          push_res(ACT_SEL_LOW, 0);
          if (sq_op == OP_ERASE) begin
            push_res(ACT_SEND, 24'(CMD_RDSR));
            sq_after = AFTER_ERASE;
            sq_phase = SQ_POLLCMD;
          end else begin
            push_res(ACT_SEND, 24'(CMD_PP));
            sq_frame = 0;
            sq_phase = SQ_ADDR;
          end
        end
        SQ_ADDR: begin
          if (sq_frame < 3) begin
            push_res(ACT_SEND, 24'(sq_addr >> (16 - 8 * sq_frame)) & 24'hFF);
            sq_frame++;
          end else if (sq_op == OP_READ) begin
            if (sq_left != 0) begin
              push_res(ACT_SEND, 24'(DUMMY));
              sq_phase = SQ_READ;
            end else begin
              push_res(ACT_SEL_HIGH, 0);
              complete();
            end
          end else if (sq_op == OP_ERASE) begin
            begin_poll(AFTER_FINAL);
          end else begin
            push_res(ACT_NEED, 0);
            sq_phase = SQ_NEED;
          end
        end
        SQ_READ: begin
          push_res(ACT_READ, 24'(b));
          sq_left--;
          if (sq_left != 0) push_res(ACT_SEND, 24'(DUMMY));
          else begin
            push_res(ACT_SEL_HIGH, 0);
            complete();
          end
        end
        SQ_DATA: begin
          if (sq_chunk != 0) begin
            push_res(ACT_NEED, 0);
            sq_phase = SQ_NEED;
          end else begin
            begin_poll(AFTER_PAGE);
          end
        end
        SQ_POLLCMD: begin
          push_res(ACT_SEND, 24'(DUMMY));
          sq_phase = SQ_POLL;
        end
        SQ_POLL: begin
          if (b[0]) push_res(ACT_SEND, 24'(DUMMY));
          else begin
            push_res(ACT_SEL_HIGH, 0);
            if (sq_after == AFTER_ERASE) begin
              push_res(ACT_SEL_LOW, 0);
              push_res(ACT_SEND, 24'(CMD_SE));
              sq_frame = 0;
              sq_phase = SQ_ADDR;
            end else if (sq_after == AFTER_PAGE && sq_left != 0) begin
              load_chunk();
              begin_wen();
            end else begin
              complete();
            end
          end
        end
        default: ;
      endcase
    end else if (it.mode == MODE_DATA && sq_phase == SQ_NEED) begin
      push_res(ACT_SEND, 24'(b));
      if (sq_chunk != 0) sq_chunk--;
      sq_left--;
      sq_addr++;
      sq_phase = SQ_DATA;
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) expected_results.push_back(burst[i]);
  endfunction

  always @(posedge clk) begin
    item_t      it;
    flash_res_t exp_r;
    if (!rst_n) begin
      sq_op = 0; sq_addr = 0; sq_left = 0; sq_chunk = 0;
      sq_frame = 0; sq_ident = 0; sq_after = AFTER_NONE;
      sq_phase = SQ_IDLE;
      expected_results.delete();
      fail_count = 0;
    end else begin
      // result side first: a result can never come from the same-edge input
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result action=%0d value=%h", out_tuser, out_tdata);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tuser !== exp_r.action) begin
            $error("action exp=%0d got=%0d", exp_r.action, out_tuser);
            fail_count++;
          end
          if (out_tdata !== exp_r.value) begin
            $error("value exp=%h got=%h", exp_r.value, out_tdata);
            fail_count++;
          end
          if (out_tlast !== exp_r.last) begin
            $error("last exp=%0d got=%0d", exp_r.last, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        it.mode = in_tuser;
        it.op = in_tdata[1:0];
        it.address = in_tdata[25:2];
        it.length = in_tdata[41:26];
        it.data_byte = in_tdata[49:42];
        predict_sequencer(it);
      end
    end
    pending_count = expected_results.size();
  end
endmodule
`default_nettype wire

[tb/sv/tb_spi_flash_command_sequencer_top.sv]
// Testbench top: drives flash sequencer transactions and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_spi_flash_command_sequencer_top;
  import sfcs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          hold_off = 1'b0;   // long receiver stall requested by stimulus
  bit          stim_done = 1'b0;

  localparam int CYCLE_LIMIT = 400000;

  always #4 clk = ~clk;

  spi_flash_command_sequencer_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  sfcs_scoreboard i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // Mostly short gaps, occasionally a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL spi_flash_command_sequencer_top");
      $finish;
    end
  end

  // Receiver: random tready, plus a long stall when asked.
  initial begin
    int g;
    int k;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        for (k = 0; k < 80; k++) @(negedge clk);
        hold_off = 1'b0;
      end
      out_tready <= 1'b1;
      g = (cycle_count % 2000 < 500) ? 0 : pick_gap();
      for (k = 0; k < g; k++) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
    end
  end

  // One transaction on the input channel, with a random gap ahead of it.
  // tvalid stays high on return; wait_drained, or a next call with a gap, drops it.
  task automatic send_event(logic [1:0] mode, logic [1:0] op, logic [23:0] addr,
                            logic [15:0] len, logic [7:0] b);
    int g;
    g = (cycle_count % 1500 < 400) ? 0 : pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {6'b0, b, len, addr, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_rx(logic [7:0] b);
    send_event(MODE_RX, 2'($urandom), 24'($urandom), 16'($urandom), b);
  endtask

  task automatic send_req(logic [1:0] op, logic [23:0] addr, logic [15:0] len);
    send_event(MODE_REQ, op, addr, len, 8'($urandom));
  endtask

  // Status replies: a few busy rounds, then ready.
  task automatic poll_until_ready(int busy_rounds);
    int k;
    send_rx(8'($urandom));            // reply to the status command byte
    for (k = 0; k < busy_rounds; k++) send_rx(8'($urandom) | 8'h01);
    send_rx(8'($urandom) & 8'hFE);
  endtask

  task automatic run_identity();
    int k;
    send_req(OP_ID, 24'($urandom), 16'($urandom));
    for (k = 0; k < 4; k++) send_rx(8'($urandom));
  endtask

  task automatic run_read(logic [23:0] addr, logic [15:0] len);
    int k;
    send_req(OP_READ, addr, len);
    for (k = 0; k < 4; k++) send_rx(8'($urandom));
    for (k = 0; k < len; k++) send_rx(8'($urandom));
    if (len != 0) send_rx(8'($urandom));   // stray byte once idle, ignored
  endtask

  task automatic run_erase(logic [23:0] addr);
    int k;
    send_req(OP_ERASE, addr, 16'($urandom));
    send_rx(8'($urandom));                 // reply to write enable
    poll_until_ready($urandom_range(0, 2));
    for (k = 0; k < 4; k++) send_rx(8'($urandom));
    poll_until_ready($urandom_range(0, 2));
  endtask

  // Buffered write; page splits and the empty trailing page fall out of the flow.
  task automatic run_write(logic [23:0] addr, logic [15:0] len);
    int k;
    int left;
    int room;
    int chunk;
    logic [23:0] cur;
    send_req(OP_WRITE, addr, len);
    left = len;
    cur = addr;
    while (left > 0) begin
      room = PAGE_BYTES - cur[7:0];
      chunk = (left < room) ? left : room;
      send_rx(8'($urandom));               // write enable reply
      for (k = 0; k < 4; k++) send_rx(8'($urandom));
      for (k = 0; k < chunk; k++) begin
        // stray received byte while host data is awaited is ignored
        if ($urandom_range(0, 15) == 0) send_rx(8'($urandom));
        send_event(MODE_DATA, 2'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
        send_rx(8'($urandom));
      end
      left -= chunk;
      cur += chunk;
      poll_until_ready($urandom_range(0, 2));
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Noise: stray received bytes, stray host data bytes and mode 3.
  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_event(MODE_DATA, 2'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
      1: send_event(2'd3, 2'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
      default: send_rx(8'($urandom));
    endcase
  endtask

  initial begin
    int n;
    int k;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle noise, each operation, extremes.
    send_rx(8'hFF);
    send_event(MODE_DATA, OP_WRITE, 24'hFFFFFF, 16'hFFFF, 8'hFF);
    send_event(2'd3, OP_WRITE, 24'hFFFFFF, 16'hFFFF, 8'hFF);
    run_identity();
    send_req(OP_ID, 24'hFFFFFF, 16'hFFFF);   // starts an identity frame
    send_req(OP_READ, 24'h0, 16'h0);        // rejected while busy
    send_rx(8'h00); send_rx(8'hFF); send_rx(8'h00); send_rx(8'hFF);
    run_read(24'hFFFFFF, 16'h0);
    run_read(24'hABCDEF, 16'd2);
    send_req(OP_WRITE, 24'h123456, 16'h0);  // empty write
    run_erase(24'hFFFFFF);
    run_write(24'hFFFFFE, 16'd3);           // page split with address wrap
    run_write(24'h000000, 16'd1);           // empty trailing page path
    wait_drained();

    // Long receiver stall while the sender keeps offering.
    hold_off = 1'b1;
    run_read(24'($urandom), 16'd6);
    wait_drained();

    // Random part.
    n = 0;
    while (items_sent < 195) begin
      case ($urandom_range(0, 9))
        0: run_identity();
        1, 2: run_read(24'($urandom), 16'($urandom_range(0, 5)));
        3: run_erase(24'($urandom));
        4, 5, 6: begin
          if ($urandom_range(0, 3) == 0)
            run_write({16'($urandom), 8'($urandom_range(240, 255))},
                      16'($urandom_range(8, 20)));
          else
            run_write(24'($urandom), 16'($urandom_range(1, 6)));
        end
        7: begin
          // request while an identity frame is open is rejected
          send_req(OP_ID, 24'($urandom), 16'($urandom));
          send_req(2'($urandom), 24'($urandom), 16'($urandom));
          for (k = 0; k < 4; k++) send_rx(8'($urandom));
        end
        default: send_noise();
      endcase
      if ($urandom_range(0, 15) == 0) wait_drained();
      n++;
      if (n % 8 == 0) begin
        hold_off = 1'b1;
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("PASS spi_flash_command_sequencer_top");
    else $display("FAIL spi_flash_command_sequencer_top");
    $finish;
  end
endmodule
`default_nettype wire
